// ===== src/two_operator_fm_voice_assert.svh =====
// Assertion macros for the two-operator FM voice checker.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef TWO_OPERATOR_FM_VOICE_ASSERT_SVH
`define TWO_OPERATOR_FM_VOICE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define FV_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/fv_pkg.sv =====
// Shared types, constants, microcode table and sine table builder of the FM voice.
// No dependencies; all other voice files but the macro header use its scoped names.
`default_nettype none

package fv_pkg;

	// Sizes
	localparam int SINE_ROM_DEPTH = 1024;
	localparam int PHASE_BITS     = 32;
	localparam int ROM_AW         = $clog2(SINE_ROM_DEPTH);
	localparam int SIN_W          = 15;
	localparam int FUNC_W         = 2;
	localparam int BASE_W         = 31;
	localparam int SAMPLE_W       = 16;
	localparam int RATIO_W        = 16;
	localparam int DEPTH_W        = 16;
	localparam int ASTEP_W        = 16;
	localparam int AMP_W          = 24;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 24;
	localparam int MUL_W          = 32;
	localparam int PROD_W         = 2 * MUL_W;

	// Fixed-point scaling of the products
	localparam int MSTEP_LSB = 12;   // base * ratio(Q4.12)
	localparam int DEV_LSB   = 27;   // base * depth(Q4.12) * sine(Q15)

	// Reset values
	localparam logic [PHASE_BITS-1:0] BASE_RESET =
		PHASE_BITS'((64'd440 << PHASE_BITS) / 64'd48000);
	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(4096);
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = '0;
	localparam logic [ASTEP_W-1:0] ASTEP_RESET = ASTEP_W'(168);
	localparam logic [AMP_W-1:0]   AMAX_RESET  = AMP_W'(4194304);

	// Item function codes
	localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_NOTE_ON  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_RATIO = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_STEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_ON = 3'd4;

	// Microprogram steps
	typedef enum logic [2:0] {
		ST_MOD_RD   = 3'd0,
		ST_DEPTH    = 3'd1,
		ST_DEV      = 3'd2,
		ST_CAR      = 3'd3,
		ST_OUT      = 3'd4,
		ST_NOTE_ON  = 3'd5,
		ST_NOTE_OFF = 3'd6
	} step_t;

	// Operand pairs of the shared multiplier
	typedef enum logic [1:0] {
		MUL_BASE_RATIO = 2'd0,
		MUL_DEPTH_MSIN = 2'd1,
		MUL_BASE_DM    = 2'd2,
		MUL_AMP_CSIN   = 2'd3
	} mul_op_t;

	// One control word
	typedef struct packed {
		logic    rom_rd;    // read the sine table
		logic    rom_car;   // table address from carrier phase, else modulator
		logic    mul_en;    // load the product register
		mul_op_t mul_op;
		logic    mod_wr;    // advance modulator phase, keep modulator sign
		logic    car_wr;    // advance carrier phase by modulated step
		logic    out_wr;    // load output word, move amplitude
		logic    on_wr;     // note on: load base step and target
		logic    off_wr;    // note off: clear target
		logic    last;      // end of program
		step_t   nxt;
	} ucode_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	// Control store
	function automatic ucode_t ucode_of(step_t s);
		ucode_t w;
		w = '0;
		unique case (s)
			ST_MOD_RD: begin
				w.rom_rd = 1'b1;
				w.mul_en = 1'b1;
				w.mul_op = MUL_BASE_RATIO;
				w.nxt    = ST_DEPTH;
			end
			ST_DEPTH: begin
				w.rom_rd  = 1'b1;
				w.rom_car = 1'b1;
				w.mul_en  = 1'b1;
				w.mul_op  = MUL_DEPTH_MSIN;
				w.mod_wr  = 1'b1;
				w.nxt     = ST_DEV;
			end
			ST_DEV: begin
				w.mul_en = 1'b1;
				w.mul_op = MUL_BASE_DM;
				w.nxt    = ST_CAR;
			end
			ST_CAR: begin
				w.mul_en = 1'b1;
				w.mul_op = MUL_AMP_CSIN;
				w.car_wr = 1'b1;
				w.nxt    = ST_OUT;
			end
			ST_OUT: begin
				w.out_wr = 1'b1;
				w.last   = 1'b1;
				w.nxt    = ST_MOD_RD;
			end
			ST_NOTE_ON: begin
				w.on_wr = 1'b1;
				w.last  = 1'b1;
				w.nxt   = ST_MOD_RD;
			end
			ST_NOTE_OFF: begin
				w.off_wr = 1'b1;
				w.last   = 1'b1;
				w.nxt    = ST_MOD_RD;
			end
			default: w = '0;
		endcase
		return w;
	endfunction

	// Quarter-wave sine table, Q30 Taylor series evaluated at elaboration
	typedef logic [SIN_W-1:0] sine_tab_t [SINE_ROM_DEPTH];

	localparam longint unsigned PI_Q30    = 64'd3373259426;
	localparam int              Q30_SHIFT = 30;
	localparam longint          Q30_HALF  = 64'sd536870912;

	function automatic sine_tab_t build_sine();
		sine_tab_t tab;
		longint    x;
		longint    term;
		longint    sum;
		longint    x2;
		for (int k = 0; k < SINE_ROM_DEPTH; k++) begin
			x = longint'((PI_Q30 * longint'(2 * k + 1)) >> (ROM_AW + 2));
			term = x;
			sum  = x;
			x2   = (x * x) >>> Q30_SHIFT;
			for (int n = 1; n <= 6; n++) begin
				term = (term * x2) >>> Q30_SHIFT;
				// Scale by the series denominator (2n)(2n+1)
				case (n)
					1: term = term / 64'sd6;
					2: term = term / 64'sd20;
					3: term = term / 64'sd42;
					4: term = term / 64'sd72;
					5: term = term / 64'sd110;
					default: term = term / 64'sd156;
				endcase
				if (n[0]) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			tab[k] = SIN_W'((sum * 32767 + Q30_HALF) >>> Q30_SHIFT);
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

// ===== src/fv_channels_if.sv =====
// Channel interfaces of the FM voice: note/tick items, samples, register writes.
// Depends on fv_pkg for field widths.
`default_nettype none

interface fv_note_if;
	logic                             valid;
	logic                             ready;
	logic [fv_pkg::FUNC_W-1:0]        func;
	logic [fv_pkg::BASE_W-1:0]        base_step;
	modport source (output valid, output func, output base_step, input ready);
	modport sink   (input valid, input func, input base_step, output ready);
endinterface

interface fv_sample_if;
	logic                               valid;
	logic                               ready;
	logic signed [fv_pkg::SAMPLE_W-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface fv_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [fv_pkg::CFG_IDX_W-1:0]     index;
	logic [fv_pkg::CFG_DATA_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/two_operator_fm_voice.sv =====
// Two-operator FM voice: one modulator sine bends the carrier step of each sample.
// Channels: note_in takes a word with func (tick, note on, note off) and base_step;
// sample_out gives one signed Q1.15 word per tick; cfg writes the five registers
// (mod_ratio, mod_depth, amp_step, amp_max, always_on) by index and is always ready.
// Timing: a tick runs five microcode steps after its acceptance; its sample is valid
// from the edge that ends the last step, and note_in is ready again at that same edge,
// so no new word is taken while a tick is in work. Note on and note off take one step
// each; the unused func code is dropped at once.
// The step count follows from the single 32x32 multiplier, which forms four products per
// tick, and the single read port of the sine table, which is read twice per tick.
// Reset: phases and amplitude clear, the base step is the 440 Hz step at 48 kHz,
// and the registers take their documented reset values. No clearing pass is needed.
// Stall: a finished sample waits in the output register while the next word is taken;
// a second tick then waits at its last step until the output register frees up.
// Depends on fv_pkg, fv_channels_if, fv_useq and fv_datapath.
`default_nettype none

module two_operator_fm_voice (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fv_note_if.sink     note_in,
	fv_sample_if.source sample_out,
	fv_cfg_if.sink      cfg
);

	logic             in_ready;
	logic             in_accept;
	fv_pkg::ucode_t   ctl;
	fv_pkg::dp_stat_t stat;

	assign in_accept     = note_in.valid && in_ready;
	assign note_in.ready = in_ready;
	assign cfg.ready     = 1'b1;

	fv_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_accept),
		.func   (note_in.func),
		.stat   (stat),
		.ready  (in_ready),
		.ctl    (ctl)
	);

	fv_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.in_accept    (in_accept),
		.in_base_step (note_in.base_step),
		.cfg_wr       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.out_ready    (sample_out.ready),
		.out_valid    (sample_out.valid),
		.out_sample   (sample_out.sample)
	);

endmodule

`default_nettype wire

// ===== src/fv_sine_rom.sv =====
// Quarter-wave sine table with registered read; folds a phase into magnitude and sign.
// Depends on fv_pkg for the table contents and sizes.
`default_nettype none

module fv_sine_rom (
	input  wire logic                          clk,
	input  wire logic                          rd_en,
	input  wire logic [fv_pkg::PHASE_BITS-1:0] phase,
	output logic      [fv_pkg::SIN_W-1:0]      mag_q,
	output logic                               neg_q
);

	localparam fv_pkg::sine_tab_t SINE_TAB = fv_pkg::build_sine();

	logic [fv_pkg::ROM_AW+1:0] pos;
	logic [fv_pkg::ROM_AW-1:0] addr;

	// Take quadrant and offset from the top phase bits, mirror odd quadrants
	assign pos  = phase[fv_pkg::PHASE_BITS-1 -: fv_pkg::ROM_AW + 2];
	assign addr = pos[fv_pkg::ROM_AW] ? ~pos[fv_pkg::ROM_AW-1:0] : pos[fv_pkg::ROM_AW-1:0];

	// Read the table, keep the half-cycle bit as the sign
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mag_q <= SINE_TAB[addr];
			neg_q <= pos[fv_pkg::ROM_AW+1];
		end
	end

endmodule

`default_nettype wire

// ===== src/fv_useq.sv =====
// Microcode sequencer of the FM voice: step counter, dispatch on the item word, control words.
// Depends on fv_pkg for the control store and step codes.
`default_nettype none

module fv_useq (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [fv_pkg::FUNC_W-1:0] func,
	input  wire fv_pkg::dp_stat_t          stat,
	output logic                           ready,
	output fv_pkg::ucode_t                 ctl
);

	logic            busy_q;
	fv_pkg::step_t   step_q;
	logic            busy_nx;
	fv_pkg::step_t   step_nx;
	fv_pkg::ucode_t  word;
	logic            hold;

	// Fetch the control word; wait at the output step while the output is full
	assign word = fv_pkg::ucode_of(step_q);
	assign hold = word.out_wr && !stat.out_free;

	// Next step: dispatch on a new word, else follow the program
	always_comb begin
		busy_nx = busy_q;
		step_nx = step_q;
		if (!busy_q) begin
			if (start) begin
				unique case (func)
					fv_pkg::FUNC_TICK: begin
						busy_nx = 1'b1;
						step_nx = fv_pkg::ST_MOD_RD;
					end
					fv_pkg::FUNC_NOTE_ON: begin
						busy_nx = 1'b1;
						step_nx = fv_pkg::ST_NOTE_ON;
					end
					fv_pkg::FUNC_NOTE_OFF: begin
						busy_nx = 1'b1;
						step_nx = fv_pkg::ST_NOTE_OFF;
					end
					default: busy_nx = 1'b0;
				endcase
			end
		end else if (!hold) begin
			if (word.last) begin
				busy_nx = 1'b0;
			end else begin
				step_nx = word.nxt;
			end
		end
	end

	// Outputs: issue the word only while running and not held
	always_comb begin
		ready = !busy_q;
		ctl   = (busy_q && !hold) ? word : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= fv_pkg::ST_MOD_RD;
		end else begin
			busy_q <= busy_nx;
			step_q <= step_nx;
		end
	end

endmodule

`default_nettype wire

// ===== src/fv_datapath.sv =====
// Datapath of the FM voice: registers, phases, shared multiplier, sine table, envelope.
// Depends on fv_pkg and fv_sine_rom; driven by control words from fv_useq.
`default_nettype none

module fv_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire fv_pkg::ucode_t                      ctl,
	output fv_pkg::dp_stat_t                         stat,
	input  wire logic                                in_accept,
	input  wire logic [fv_pkg::BASE_W-1:0]           in_base_step,
	input  wire logic                                cfg_wr,
	input  wire logic [fv_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [fv_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                out_ready,
	output logic                                     out_valid,
	output logic signed [fv_pkg::SAMPLE_W-1:0]       out_sample
);

	localparam int PB = fv_pkg::PHASE_BITS;

	// Configuration
	logic [fv_pkg::RATIO_W-1:0] ratio_q;
	logic [fv_pkg::DEPTH_W-1:0] depth_q;
	logic [fv_pkg::ASTEP_W-1:0] astep_q;
	logic [fv_pkg::AMP_W-1:0]   amax_q;
	logic                       aon_q;

	// Voice state
	logic [PB-1:0]              cphase_q;
	logic [PB-1:0]              mphase_q;
	logic [PB-1:0]              cbase_q;
	logic [fv_pkg::AMP_W-1:0]   amp_q;
	logic [fv_pkg::AMP_W-1:0]   tgt_q;

	// Work registers
	logic [fv_pkg::BASE_W-1:0]  base_q;
	logic [fv_pkg::PROD_W-1:0]  prod_q;
	logic                       msign_q;
	logic signed [fv_pkg::SAMPLE_W-1:0] out_q;
	logic                       out_valid_q;

	// Sine table
	logic [fv_pkg::SIN_W-1:0]   rom_mag;
	logic                       rom_neg;

	// Combinational
	logic [fv_pkg::MUL_W-1:0]   mul_a;
	logic [fv_pkg::MUL_W-1:0]   mul_b;
	logic [fv_pkg::AMP_W-1:0]   amp_eff;
	logic [PB-1:0]              mstep;
	logic [PB-1:0]              dev;
	logic [PB-1:0]              cstep;
	logic [fv_pkg::SAMPLE_W-1:0] smag;
	logic [fv_pkg::AMP_W-1:0]   amp_dn_gap;
	logic [fv_pkg::AMP_W-1:0]   amp_up_gap;
	logic [fv_pkg::AMP_W-1:0]   astep_ext;
	logic [fv_pkg::AMP_W-1:0]   amp_nx;

	fv_sine_rom u_rom (
		.clk   (clk),
		.rd_en (ctl.rom_rd),
		.phase (ctl.rom_car ? cphase_q : mphase_q),
		.mag_q (rom_mag),
		.neg_q (rom_neg)
	);

	// Select multiplier operands
	always_comb begin
		amp_eff = aon_q ? amax_q : amp_q;
		case (ctl.mul_op)
			fv_pkg::MUL_BASE_RATIO: begin
				mul_a = fv_pkg::MUL_W'(cbase_q);
				mul_b = fv_pkg::MUL_W'(ratio_q);
			end
			fv_pkg::MUL_DEPTH_MSIN: begin
				mul_a = fv_pkg::MUL_W'(depth_q);
				mul_b = fv_pkg::MUL_W'(rom_mag);
			end
			fv_pkg::MUL_BASE_DM: begin
				mul_a = fv_pkg::MUL_W'(cbase_q);
				mul_b = prod_q[fv_pkg::MUL_W-1:0];
			end
			default: begin
				mul_a = fv_pkg::MUL_W'(amp_eff);
				mul_b = fv_pkg::MUL_W'(rom_mag);
			end
		endcase
	end

	// Scale products back to phase steps and sample magnitude
	assign mstep = prod_q[fv_pkg::MSTEP_LSB +: PB];
	assign dev   = prod_q[fv_pkg::DEV_LSB +: PB];
	assign cstep = msign_q ? (cbase_q - dev) : (cbase_q + dev);
	assign smag  = fv_pkg::SAMPLE_W'(prod_q[fv_pkg::AMP_W +: fv_pkg::SIN_W]);

	// Move amplitude toward target by one step, clamp at the target; always-on holds the maximum
	always_comb begin
		astep_ext  = fv_pkg::AMP_W'(astep_q);
		amp_dn_gap = amp_q - tgt_q;
		amp_up_gap = tgt_q - amp_q;
		amp_nx     = amp_q;
		if (aon_q) begin
			amp_nx = amax_q;
		end else if (amp_q > tgt_q) begin
			amp_nx = (amp_dn_gap > astep_ext) ? (amp_q - astep_ext) : tgt_q;
		end else if (amp_q < tgt_q) begin
			amp_nx = (amp_up_gap > astep_ext) ? (amp_q + astep_ext) : tgt_q;
		end
	end

	// Capture the item payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			base_q <= in_base_step;
		end
	end

	// Shared multiplier, one product on each step that enables it; modulator sign and output word
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= fv_pkg::PROD_W'(mul_a * mul_b);
		end
		if (ctl.mod_wr) begin
			msign_q <= rom_neg;
		end
		if (ctl.out_wr) begin
			out_q <= rom_neg ? (fv_pkg::SAMPLE_W'(0) - smag) : smag;
		end
	end

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= fv_pkg::RATIO_RESET;
			depth_q <= fv_pkg::DEPTH_RESET;
			astep_q <= fv_pkg::ASTEP_RESET;
			amax_q  <= fv_pkg::AMAX_RESET;
			aon_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				fv_pkg::CFG_MOD_RATIO: ratio_q <= cfg_data[fv_pkg::RATIO_W-1:0];
				fv_pkg::CFG_MOD_DEPTH: depth_q <= cfg_data[fv_pkg::DEPTH_W-1:0];
				fv_pkg::CFG_AMP_STEP:  astep_q <= cfg_data[fv_pkg::ASTEP_W-1:0];
				fv_pkg::CFG_AMP_MAX:   amax_q  <= cfg_data[fv_pkg::AMP_W-1:0];
				fv_pkg::CFG_ALWAYS_ON: aon_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Voice state updates as the control word directs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cphase_q <= '0;
			mphase_q <= '0;
			cbase_q  <= fv_pkg::BASE_RESET;
			amp_q    <= '0;
			tgt_q    <= '0;
		end else begin
			if (ctl.mod_wr) begin
				mphase_q <= mphase_q + mstep;
			end
			if (ctl.car_wr) begin
				cphase_q <= cphase_q + cstep;
			end
			if (ctl.out_wr) begin
				amp_q <= amp_nx;
			end
			if (ctl.on_wr) begin
				cbase_q <= PB'(base_q);
				tgt_q   <= amax_q;
			end
			if (ctl.off_wr) begin
				tgt_q <= '0;
			end
		end
	end

	// Output word register: load on the output step, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_sample    = out_q;

endmodule

`default_nettype wire

// ===== src/fv_checker.sv =====
// Port-level checker of the FM voice, bound to the top level.
// Depends on fv_pkg and the macros in two_operator_fm_voice_assert.svh.
`default_nettype none
`include "two_operator_fm_voice_assert.svh"

module fv_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic [fv_pkg::FUNC_W-1:0]       in_func,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [fv_pkg::SAMPLE_W-1:0]     out_sample
);

	logic in_work;
	logic out_stall;

	// Words that start a program, and a sample held by the receiver
	assign in_work   = in_valid && in_ready &&
		(in_func == fv_pkg::FUNC_TICK || in_func == fv_pkg::FUNC_NOTE_ON ||
		in_func == fv_pkg::FUNC_NOTE_OFF);
	assign out_stall = out_valid && !out_ready;

	// A stalled sample stays offered
	`FV_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "sample dropped while stalled")

	// A stalled sample keeps its value
	`FV_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_sample), "sample changed while stalled")

	// A word with work to do makes the input busy next cycle
	`FV_ASSERT_NEXT(a_busy_after_word, in_work, !in_ready, "input ready while a word is in work")

	// A new sample appears only at the end of a tick program
	`FV_ASSERT_IMPLY(a_out_from_work, $rose(out_valid), !$past(in_ready), "sample while idle")

endmodule

bind two_operator_fm_voice fv_checker u_fv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (note_in.valid),
	.in_ready   (note_in.ready),
	.in_func    (note_in.func),
	.out_valid  (sample_out.valid),
	.out_ready  (sample_out.ready),
	.out_sample (sample_out.sample)
);

`default_nettype wire

// ===== verif/two_operator_fm_voice_tb.sv =====
// Self-checking bench for the two-operator FM voice: drives note and tick words,
// writes the five registers between phases, and predicts every sample bit for bit.
// Depends on fv_pkg, fv_channels_if and the two_operator_fm_voice top level.
`timescale 1ns / 100ps

module two_operator_fm_voice_tb;

	localparam int SINE_DEPTH     = fv_pkg::SINE_ROM_DEPTH;
	localparam int PH_BITS        = fv_pkg::PHASE_BITS;
	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 9;
	localparam int SETTLE_CYCLES  = 10;
	localparam int TAIL_CYCLES    = 20;
	localparam int LONG_HOLD      = 80;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES  = 9;

	// Codes the package leaves unnamed
	localparam logic [fv_pkg::FUNC_W-1:0]    FUNC_SPARE = 2'd3;
	localparam logic [fv_pkg::CFG_IDX_W-1:0] CFG_SPARE  = 3'd7;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint          ONE_Q30 = 64'sd1073741824;

	logic clk = 1'b0;
	logic arst_n;

	fv_note_if   note_if ();
	fv_sample_if sample_if ();
	fv_cfg_if    cfg_if ();

	two_operator_fm_voice u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.note_in   (note_if),
		.sample_out(sample_if),
		.cfg       (cfg_if)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Predicted voice state and register copies
	int                 sine_quarter [SINE_DEPTH];
	logic [31:0]        car_phase;
	logic [31:0]        mod_phase;
	logic [31:0]        car_base;
	logic [31:0]        mod_step;
	logic [23:0]        amp_level;
	logic [23:0]        amp_goal;
	logic [15:0]        ratio_q;
	logic [15:0]        depth_q;
	logic [15:0]        amp_inc;
	logic [23:0]        amp_peak;
	logic               hold_peak;

	logic signed [15:0] expected_samples [$];
	logic signed [15:0] want;
	int                 mismatches = 0;
	int                 idle_cycles = 0;

	// Stall control shared by the stimulus and the sink
	int source_idle_pct = 0;
	int sink_idle_pct   = 0;
	int holds_asked     = 0;
	int holds_done      = 0;
	int hold_left       = 0;
	int stall_left      = 0;

	// Quarter-wave sine, Q30 Taylor series rounded to Q15
	function automatic void build_sine_quarter();
		longint x;
		longint term;
		longint sum;
		longint x2;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			x = longint'((PI_Q30 * longint'(2 * k + 1)) / longint'(4 * SINE_DEPTH));
			term = x;
			sum  = x;
			x2   = (x * x) / ONE_Q30;
			for (int n = 1; n <= 6; n++) begin
				term = (term * x2) / ONE_Q30;
				term = term / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			sine_quarter[k] = int'((sum * 32767 + ONE_Q30 / 2) / ONE_Q30);
		end
	endfunction

	// Signed Q15 sine of a phase, folded from the quarter wave
	function automatic int sine_at(logic [31:0] ph);
		longint unsigned hi;
		longint unsigned lo;
		longint unsigned pos;
		longint unsigned quad;
		longint unsigned k;
		int              v;
		hi   = ph >> 16;
		lo   = ph & 32'hFFFF;
		pos  = (hi * (4 * SINE_DEPTH) + ((lo * (4 * SINE_DEPTH)) >> 16)) >> (PH_BITS - 16);
		quad = (pos / SINE_DEPTH) & 3;
		k    = pos % SINE_DEPTH;
		v    = quad[0] ? sine_quarter[SINE_DEPTH - 1 - k] : sine_quarter[k];
		return quad[1] ? -v : v;
	endfunction

	// Modulator step is the base step times the Q4.12 ratio
	function automatic void refresh_mod_step();
		longint unsigned hi;
		longint unsigned lo;
		hi       = car_base >> 16;
		lo       = car_base & 32'hFFFF;
		mod_step = 32'((hi * ratio_q) * 16 + ((lo * ratio_q) >> 12));
	endfunction

	// Produce one sample and advance phases and amplitude
	function automatic logic signed [15:0] next_sample();
		int              ms;
		int              cs;
		longint unsigned mag;
		longint unsigned dm;
		longint unsigned bh;
		longint unsigned bl;
		longint unsigned dev;
		longint unsigned prod;
		logic [31:0]     cstep;
		logic [15:0]     s;
		ms    = sine_at(mod_phase);
		mag   = (ms < 0) ? -ms : ms;
		dm    = depth_q * mag;
		bh    = car_base >> 24;
		bl    = car_base & 32'hFFFFFF;
		dev   = ((bh * dm) + ((bl * dm) >> 24)) >> 3;
		mod_phase = mod_phase + mod_step;
		cstep = (ms < 0) ? car_base - dev[31:0] : car_base + dev[31:0];
		if (hold_peak) begin
			amp_level = amp_peak;
		end
		cs   = sine_at(car_phase);
		mag  = (cs < 0) ? -cs : cs;
		prod = mag * amp_level;
		s    = 16'(prod >> 24);
		if (cs < 0) begin
			s = -s;
		end
		car_phase = car_phase + cstep;
		// Ramp toward the target without overshoot
		if (!hold_peak) begin
			if (amp_level > amp_goal) begin
				amp_level = (amp_level - amp_goal > amp_inc) ? amp_level - amp_inc : amp_goal;
			end else if (amp_level < amp_goal) begin
				amp_level = (amp_goal - amp_level > amp_inc) ? amp_level + amp_inc : amp_goal;
			end
		end
		return s;
	endfunction

	// Track register writes and accepted words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_phase = '0;
			mod_phase = '0;
			car_base  = 32'((64'd440 << 32) / 64'd48000);
			mod_step  = car_base;
			amp_level = '0;
			amp_goal  = '0;
			ratio_q   = 16'd4096;
			depth_q   = '0;
			amp_inc   = 16'd168;
			amp_peak  = 24'd4194304;
			hold_peak = 1'b0;
		end else begin
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
					fv_pkg::CFG_MOD_RATIO: begin
						ratio_q = cfg_if.data[15:0];
						refresh_mod_step();
					end
					fv_pkg::CFG_MOD_DEPTH: depth_q   = cfg_if.data[15:0];
					fv_pkg::CFG_AMP_STEP:  amp_inc   = cfg_if.data[15:0];
					fv_pkg::CFG_AMP_MAX:   amp_peak  = cfg_if.data[23:0];
					fv_pkg::CFG_ALWAYS_ON: hold_peak = cfg_if.data[0];
					default: ;
				endcase
			end
			if (note_if.valid && note_if.ready) begin
				case (note_if.func)
					fv_pkg::FUNC_TICK: expected_samples.push_back(next_sample());
					fv_pkg::FUNC_NOTE_ON: begin
						car_base = {1'b0, note_if.base_step};
						refresh_mod_step();
						amp_goal = amp_peak;
					end
					fv_pkg::FUNC_NOTE_OFF: amp_goal = '0;
					default: ;
				endcase
			end
		end
	end

	// Compare each sample word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && sample_if.valid && sample_if.ready) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected sample, expected none, actual %0d",
					$time, sample_if.sample);
				mismatches++;
			end else begin
				want = expected_samples.pop_front();
				if (sample_if.sample !== want) begin
					$display("%0t: sample mismatch, expected %0d, actual %0d",
						$time, want, sample_if.sample);
					mismatches++;
				end
			end
		end
	end

	// Drive sample ready: long hold on request, else random stall bursts
	always @(negedge clk) begin
		if (holds_done != holds_asked) begin
			hold_left = LONG_HOLD;
			holds_done++;
		end
		if (hold_left > 0) begin
			sample_if.ready = 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			sample_if.ready = 1'b0;
			stall_left--;
		end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
			sample_if.ready = 1'b0;
			stall_left = $urandom_range(0, 6);
		end else begin
			sample_if.ready = 1'b1;
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((note_if.valid && note_if.ready) || (sample_if.valid && sample_if.ready) ||
			(cfg_if.valid && cfg_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("two_operator_fm_voice_tb: FAIL");
			$finish;
		end
	end

	// Offer one word, with an optional gap first; leaves valid high
	task automatic send_word(input logic [1:0] fn, input logic [30:0] step);
		if (source_idle_pct > 0 && $urandom_range(0, 99) < source_idle_pct) begin
			note_if.valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		note_if.valid     = 1'b1;
		note_if.func      = fn;
		note_if.base_step = step;
		@(posedge clk);
		while (!note_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// Drop valid, wait for every sample, then let note words settle
	task automatic wait_drained();
		note_if.valid = 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_all_regs(input logic [15:0] ratio, input logic [15:0] depth,
		input logic [15:0] inc, input logic [23:0] peak, input logic hold);
		write_reg(fv_pkg::CFG_MOD_RATIO, {8'($urandom), ratio});
		write_reg(fv_pkg::CFG_MOD_DEPTH, {8'($urandom), depth});
		write_reg(fv_pkg::CFG_AMP_STEP, {8'($urandom), inc});
		write_reg(fv_pkg::CFG_AMP_MAX, peak);
		write_reg(fv_pkg::CFG_ALWAYS_ON, {23'($urandom), hold});
	endtask

	function automatic logic [30:0] pick_base_step();
		case ($urandom_range(0, 5))
			0: return '1;
			1: return '0;
			2: return 31'($urandom);
			default: return 31'($urandom) >> $urandom_range(4, 24);
		endcase
	endfunction

	// Mostly ticks inside note on/off spans, some spare codes as noise
	task automatic send_random_words(input int count);
		int          sent;
		int          roll;
		logic [1:0]  fn;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				fn = FUNC_SPARE;
			end else if (roll < 11) begin
				fn = fv_pkg::FUNC_NOTE_ON;
			end else if (roll < 17) begin
				fn = fv_pkg::FUNC_NOTE_OFF;
			end else begin
				fn = fv_pkg::FUNC_TICK;
			end
			send_word(fn, pick_base_step());
			if (fn != FUNC_SPARE) begin
				sent++;
			end
		end
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_word(fv_pkg::FUNC_TICK, 31'($urandom));
	endtask

	// Field extremes, every function code, ratio change, always-on
	task automatic test_directed();
		source_idle_pct = 0;
		sink_idle_pct   = 0;
		send_ticks(1);
		wait_drained();
		write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0);
		send_word(fv_pkg::FUNC_NOTE_ON, 31'h7FFFFFFF);
		send_ticks(3);
		send_word(FUNC_SPARE, 31'h7FFFFFFF);
		send_word(fv_pkg::FUNC_NOTE_OFF, 31'h2AAAAAAA);
		send_ticks(2);
		send_word(fv_pkg::FUNC_NOTE_ON, 31'h0);
		send_ticks(2);
		send_word(fv_pkg::FUNC_NOTE_ON, 31'h1);
		send_ticks(1);
		// Ratio write must retune the modulator at once
		wait_drained();
		write_reg(fv_pkg::CFG_MOD_RATIO, 24'h000800);
		send_ticks(2);
		wait_drained();
		write_reg(fv_pkg::CFG_ALWAYS_ON, 24'hFFFFFF);
		send_ticks(2);
		send_word(fv_pkg::FUNC_NOTE_OFF, 31'h0);
		send_ticks(2);
		wait_drained();
		write_reg(fv_pkg::CFG_ALWAYS_ON, 24'h000000);
		write_reg(CFG_SPARE, 24'hFFFFFF);
		send_ticks(2);
		send_word(fv_pkg::FUNC_NOTE_ON, 31'h40000000);
		send_ticks(2);
	endtask

	// Several register settings, extremes first, random traffic in each
	task automatic test_random_settings();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			case (p)
				0: write_all_regs(16'h0000, 16'h0000, 16'h0000, 24'h000000, 1'b0);
				1: write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1);
				2: write_all_regs(16'd4096, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0);
				default: write_all_regs(16'($urandom),
					($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 4096)),
					16'($urandom_range(0, 65535)), 24'($urandom),
					$urandom_range(0, 3) == 0);
			endcase
			source_idle_pct = (p % 3 == 0) ? 0 : 10 * (p % 3);
			sink_idle_pct   = (p % 4 == 1) ? 0 : 25;
			send_random_words(110);
		end
	endtask

	// Hold the sink off long enough to fill the block, then drain fully
	task automatic test_backpressure();
		wait_drained();
		write_all_regs(16'($urandom), 16'($urandom), 16'hFFFF, 24'hFFFFFF, 1'b1);
		source_idle_pct = 0;
		sink_idle_pct   = 0;
		holds_asked++;
		send_ticks(24);
		wait_drained();
		sink_idle_pct = 30;
		send_random_words(20);
	endtask

	// Closing stretch at full rate on both sides
	task automatic test_full_rate();
		wait_drained();
		write_all_regs(16'($urandom), 16'($urandom_range(0, 8192)), 16'($urandom),
			24'($urandom), 1'b0);
		source_idle_pct = 0;
		sink_idle_pct   = 0;
		send_random_words(100);
	endtask

	initial begin
		arst_n            = 1'b0;
		note_if.valid     = 1'b0;
		note_if.func      = fv_pkg::FUNC_TICK;
		note_if.base_step = '0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = fv_pkg::CFG_MOD_RATIO;
		cfg_if.data       = '0;
		sample_if.ready   = 1'b0;
		build_sine_quarter();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_settings();
		test_backpressure();
		test_full_rate();

		note_if.valid = 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_samples.size() == 0) begin
			$display("two_operator_fm_voice_tb: PASS");
		end else begin
			$display("two_operator_fm_voice_tb: FAIL");
		end
		$finish;
	end

endmodule
